// ===== hw/rtl/fstc_pkg.sv =====
// Shared types and constants for the fan speed trend controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package fstc_pkg;

	// Field widths
	localparam int TEMP_IN_W = 18;  // millidegree sample
	localparam int TEMP_W    = 8;   // whole degrees
	localparam int RPM_W     = 13;
	localparam int STEP_W    = 5;
	localparam int FIDX_W    = 2;

	// Stream payload layout
	localparam int IN_TDATA_W   = 24;
	localparam int OUT_TDATA_W  = 24;
	localparam int OUT_IDX_LSB  = 0;
	localparam int OUT_SPD_LSB  = OUT_IDX_LSB + FIDX_W;
	localparam int OUT_STEP_LSB = OUT_SPD_LSB + RPM_W;
	localparam int OUT_USED_W   = OUT_STEP_LSB + STEP_W;

	// Configuration port
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAN_MIN_RPM = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAN_MAX_RPM = 2'd3;

	localparam logic [TEMP_W-1:0] TEMP_LOW_RST    = 8'd70;
	localparam logic [TEMP_W-1:0] TEMP_HIGH_RST   = 8'd80;
	localparam logic [RPM_W-1:0]  FAN_MIN_RPM_RST = 13'd1000;
	localparam logic [RPM_W-1:0]  FAN_MAX_RPM_RST = 13'd2200;

	// Millidegree to degree: floor(x/1000) == (x*RECIP) >> SHIFT for x < 493448
	localparam int MILLI_RECIP_W = 19;
	localparam logic [MILLI_RECIP_W-1:0] MILLI_RECIP = 19'd268436;
	localparam int MILLI_SHIFT = 28;
	localparam int MILLI_PROD_W = TEMP_IN_W + MILLI_RECIP_W;
	localparam int DEG_RAW_W = TEMP_W + 1;   // up to 262 degrees before clamp
	localparam logic [DEG_RAW_W-1:0] DEG_MAX = 9'd255;

	// Trend counting
	localparam int CNT_W = 2;
	localparam logic [CNT_W-1:0] TREND_HIT = 2'd2;

	// Serial divider
	localparam int DIVD_W = 18;
	localparam int DIVS_W = 8;

	// Remap request queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [TEMP_W-1:0] temp_low;
		logic [TEMP_W-1:0] temp_high;
		logic [RPM_W-1:0]  fan_min_rpm;
		logic [RPM_W-1:0]  fan_max_rpm;
	} cfg_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		logic              first;   // first sample after reset: always emit
	} remap_req_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_CLASS
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_STEP_DIV,
		B_CHECK,
		B_SPD_GO,
		B_SPD_DIV,
		B_EMIT
	} back_state_t;

endpackage

// ===== hw/rtl/fstc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fstc_pkg for operand widths.
`timescale 1ns / 1ps

module fstc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [fstc_pkg::DIVD_W-1:0] dividend,
	input  logic [fstc_pkg::DIVS_W-1:0] divisor,
	output logic                      done,
	output logic [fstc_pkg::DIVD_W-1:0] quotient
);
	import fstc_pkg::*;

	localparam int ITER_W = $clog2(DIVD_W + 1);

	logic                run_q;
	logic                done_q;
	logic [ITER_W-1:0]   iter_q;
	logic [DIVS_W-1:0]   rem_q;
	logic [DIVS_W-1:0]   dvs_q;
	logic [DIVD_W-1:0]   quo_q;
	logic [DIVS_W:0]     trial;
	logic                fits;

	// next partial remainder with the next dividend bit shifted in
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= run_q && (iter_q == ITER_W'(1));
			if (start) begin
				run_q  <= 1'b1;
				iter_q <= ITER_W'(DIVD_W);
			end else if (run_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// datapath: quotient bits replace dividend bits as they shift out
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/fstc_queue.sv =====
// Short FIFO of remap requests between the front and back parts.
// Depends on fstc_pkg for the entry type and depth.
`timescale 1ns / 1ps

module fstc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fstc_pkg::remap_req_t push_data,
	output logic                 full,
	input  logic                 pop,
	output fstc_pkg::remap_req_t head,
	output logic                 empty
);
	import fstc_pkg::*;

	remap_req_t          entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     fill_q;

	assign full  = fill_q == (QPTR_W+1)'(QDEPTH);
	assign empty = fill_q == '0;
	assign head  = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPTR_W+1)'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/fstc_front.sv =====
// Front part: accepts samples, converts to degrees, tracks the rise/fall
// trend and posts remap requests. Depends on fstc_pkg.
`timescale 1ns / 1ps

module fstc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fstc_pkg::IN_TDATA_W-1:0] s_tdata,   // [17:0] temp_milli
	output logic                            q_push,
	output fstc_pkg::remap_req_t            q_req,
	input  logic                            q_full
);
	import fstc_pkg::*;

	front_state_t         state_q, state_d;
	logic [TEMP_IN_W-1:0] milli_q;
	logic [TEMP_W-1:0]    temp_q;
	logic                 started_q;
	logic [TEMP_W-1:0]    prev_q;
	logic [CNT_W-1:0]     rise_q;
	logic [CNT_W-1:0]     fall_q;

	logic [MILLI_PROD_W-1:0] prod;
	logic [DEG_RAW_W-1:0]    deg_raw;
	logic [TEMP_W-1:0]       deg;
	logic [CNT_W-1:0]        rise_n, fall_n;
	logic                    need_remap;
	logic                    upd;

	// divide by 1000 through the reciprocal, saturate at 255 degrees
	assign prod    = MILLI_PROD_W'(milli_q) * MILLI_PROD_W'(MILLI_RECIP);
	assign deg_raw = prod[MILLI_SHIFT +: DEG_RAW_W];
	assign deg     = (deg_raw > DEG_MAX) ? DEG_MAX[TEMP_W-1:0] : deg_raw[TEMP_W-1:0];

	// trend classification of the converted sample
	always_comb begin
		rise_n = rise_q;
		fall_n = fall_q;
		if (temp_q < prev_q) begin
			fall_n = fall_q + CNT_W'(1);
			rise_n = '0;
		end
		if (temp_q > prev_q) begin
			rise_n = rise_q + CNT_W'(1);
			fall_n = '0;
		end
		need_remap = !started_q || (rise_n == TREND_HIT) || (fall_n == TREND_HIT);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		q_push   = 1'b0;
		upd      = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = F_CONV;
				end
			end
			F_CONV: begin
				state_d = F_CLASS;
			end
			F_CLASS: begin
				if (!(need_remap && q_full)) begin
					upd     = 1'b1;
					q_push  = need_remap;
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	assign q_req.temp  = temp_q;
	assign q_req.first = !started_q;

	// sample registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			milli_q <= s_tdata[TEMP_IN_W-1:0];
		end
		if (state_q == F_CONV) begin
			temp_q <= deg;
		end
	end

	// trend state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			prev_q    <= '0;
			rise_q    <= '0;
			fall_q    <= '0;
		end else if (upd) begin
			started_q <= 1'b1;
			prev_q    <= temp_q;
			if (!started_q) begin
				rise_q <= CNT_W'(1);
				fall_q <= CNT_W'(1);
			end else if (need_remap) begin
				rise_q <= '0;
				fall_q <= '0;
			end else begin
				rise_q <= rise_n;
				fall_q <= fall_n;
			end
		end
	end

endmodule

// ===== hw/rtl/fstc_back.sv =====
// Back part: maps a temperature to a speed step, computes the fan speed
// and emits one result per fan. Depends on fstc_pkg and fstc_div.
`timescale 1ns / 1ps

module fstc_back #(
	parameter int NUM_FANS = 4,
	parameter int STEPS    = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fstc_pkg::cfg_t                   cfg,
	input  fstc_pkg::remap_req_t             head,
	input  logic                             q_empty,
	output logic                             q_pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [fstc_pkg::OUT_TDATA_W-1:0] m_tdata,  // [1:0] fan_index,
	                                                   // [14:2] fan_speed_rpm,
	                                                   // [19:15] fan_step
	output logic                             m_tlast   // last_fan
);
	import fstc_pkg::*;

	localparam int FCW = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;
	localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(STEPS);
	localparam logic [FCW-1:0]    FAN_LAST = FCW'(NUM_FANS - 1);

	// divide by STEPS through the reciprocal; exact for any 18-bit product
	// since the rounding error times the dividend stays below 2^SPD_SHIFT
	localparam int SPD_SHIFT   = DIVD_W + STEP_W;
	localparam int SPD_RECIP_W = SPD_SHIFT + 1;
	localparam logic [SPD_RECIP_W-1:0] SPD_RECIP =
		SPD_RECIP_W'((2 ** SPD_SHIFT + STEPS - 1) / STEPS);
	localparam int SPD_PROD_W  = DIVD_W + SPD_RECIP_W;

	back_state_t       state_q, state_d;
	logic              first_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] cur_step_q;
	logic [DIVD_W-1:0] prod_q;
	logic              neg_q;
	logic [RPM_W-1:0]  spd_quo_q;
	logic [RPM_W-1:0]  spd_q;
	logic [FCW-1:0]    fan_q;
	logic              m_valid_q;
	logic [FIDX_W-1:0] out_fan_q;
	logic [RPM_W-1:0]  out_spd_q;
	logic [STEP_W-1:0] out_step_q;
	logic              out_last_q;

	logic              div_start;
	logic [DIVD_W-1:0] div_dividend;
	logic [DIVS_W-1:0] div_divisor;
	logic              div_done;
	logic [DIVD_W-1:0] div_quo;

	logic              step_ld, prod_ld, quo_ld, spd_ld, out_load;
	logic [STEP_W-1:0] step_d;
	logic              span_pos;
	logic              emit;
	logic              rng_neg;
	logic [RPM_W-1:0]  rng_mag;
	logic [SPD_PROD_W-1:0] spd_prod;
	logic [RPM_W-1:0]  quo_rpm;
	logic              fan_last;
	logic [FCW+1:0]    fan_ext;

	fstc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign span_pos = cfg.temp_high > cfg.temp_low;
	assign emit     = first_q || (step_q != cur_step_q);
	assign rng_neg  = cfg.fan_max_rpm < cfg.fan_min_rpm;
	assign rng_mag  = rng_neg ? (cfg.fan_min_rpm - cfg.fan_max_rpm)
	                          : (cfg.fan_max_rpm - cfg.fan_min_rpm);
	assign spd_prod = SPD_PROD_W'(prod_q) * SPD_PROD_W'(SPD_RECIP);
	assign quo_rpm  = spd_prod[SPD_SHIFT +: RPM_W];
	assign fan_last = fan_q == FAN_LAST;
	assign fan_ext  = {2'b00, fan_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer
	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		step_ld      = 1'b0;
		step_d       = '0;
		prod_ld      = 1'b0;
		quo_ld       = 1'b0;
		spd_ld       = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (!span_pos) begin
						// inverted or empty span: all or nothing
						step_ld = 1'b1;
						step_d  = (head.temp >= cfg.temp_high) ? STEP_MAX : '0;
						state_d = B_CHECK;
					end else if (head.temp <= cfg.temp_low) begin
						step_ld = 1'b1;
						state_d = B_CHECK;
					end else begin
						div_start    = 1'b1;
						div_dividend = DIVD_W'(head.temp - cfg.temp_low) * DIVD_W'(STEPS);
						div_divisor  = cfg.temp_high - cfg.temp_low;
						state_d      = B_STEP_DIV;
					end
				end
			end
			B_STEP_DIV: begin
				if (div_done) begin
					step_ld = 1'b1;
					step_d  = (div_quo > DIVD_W'(STEPS)) ? STEP_MAX : div_quo[STEP_W-1:0];
					state_d = B_CHECK;
				end
			end
			B_CHECK: begin
				if (emit) begin
					prod_ld = 1'b1;
					state_d = B_SPD_GO;
				end else begin
					state_d = B_IDLE;
				end
			end
			B_SPD_GO: begin
				quo_ld  = 1'b1;
				state_d = B_SPD_DIV;
			end
			B_SPD_DIV: begin
				spd_ld  = 1'b1;
				state_d = B_EMIT;
			end
			B_EMIT: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					if (fan_last) begin
						state_d = B_IDLE;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_step_q <= '0;
			fan_q      <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (prod_ld) begin
				cur_step_q <= step_q;
			end
			if (spd_ld) begin
				fan_q <= '0;
			end else if (out_load) begin
				fan_q <= fan_q + FCW'(1);
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			first_q <= head.first;
		end
		if (step_ld) begin
			step_q <= step_d;
		end
		if (prod_ld) begin
			prod_q <= DIVD_W'(step_q) * DIVD_W'(rng_mag);
			neg_q  <= rng_neg;
		end
		if (quo_ld) begin
			spd_quo_q <= quo_rpm;
		end
		// truncation toward zero: subtract the magnitude quotient when falling
		if (spd_ld) begin
			spd_q <= neg_q ? (cfg.fan_min_rpm - spd_quo_q) : (cfg.fan_min_rpm + spd_quo_q);
		end
		if (out_load) begin
			out_fan_q  <= fan_ext[FIDX_W-1:0];
			out_spd_q  <= spd_q;
			out_step_q <= cur_step_q;
			out_last_q <= fan_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), out_step_q, out_spd_q, out_fan_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== hw/rtl/fan_speed_trend_controller.sv =====
// Top level of the fan speed trend controller: configuration registers,
// front part, remap queue and back part. Depends on fstc_pkg and submodules.
`timescale 1ns / 1ps

// Takes one millidegree temperature sample per stream request and drives a
// speed step and a fan speed for each fan from it. A sample is taken in the
// front part and occupies it while it is accepted, converted to degrees and
// classified by its rise/fall trend; the front is then ready again unless
// the sample needs a remap and the two-entry remap queue is full. The time
// a remap costs the back part is set mostly by the serial divider, which
// produces one quotient bit per cycle for the step (span divide); the speed
// divide by STEPS is a reciprocal multiply, not a serial divide. A remap
// whose span is inverted or empty or whose temperature is at or below
// temp_low skips the span divide. A remap that leaves the step unchanged,
// other than the first, ends after the step is known, with no results.
// Results leave through an output register, NUM_FANS per step change, the
// final fan flagged on tlast; a stalled output holds the back part in its
// emit phase. Configuration may be written only while idle.

module fan_speed_trend_controller #(
	parameter int NUM_FANS = 4,
	parameter int STEPS    = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_we,
	input  logic [fstc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fstc_pkg::CFG_W-1:0]       cfg_data,
	// samples
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [fstc_pkg::IN_TDATA_W-1:0]  s_tdata,  // [17:0] temp_milli
	// results
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [fstc_pkg::OUT_TDATA_W-1:0] m_tdata,  // [1:0] fan_index,
	                                                   // [14:2] fan_speed_rpm,
	                                                   // [19:15] fan_step
	output logic                             m_tlast   // last_fan
);
	import fstc_pkg::*;

	cfg_t       cfg_q;
	logic       q_push, q_full, q_pop, q_empty;
	remap_req_t q_req, q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_low    <= TEMP_LOW_RST;
			cfg_q.temp_high   <= TEMP_HIGH_RST;
			cfg_q.fan_min_rpm <= FAN_MIN_RPM_RST;
			cfg_q.fan_max_rpm <= FAN_MAX_RPM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP_LOW:    cfg_q.temp_low    <= cfg_data[TEMP_W-1:0];
				REG_TEMP_HIGH:   cfg_q.temp_high   <= cfg_data[TEMP_W-1:0];
				REG_FAN_MIN_RPM: cfg_q.fan_min_rpm <= cfg_data[RPM_W-1:0];
				REG_FAN_MAX_RPM: cfg_q.fan_max_rpm <= cfg_data[RPM_W-1:0];
				default: ;
			endcase
		end
	end

	fstc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_push   (q_push),
		.q_req    (q_req),
		.q_full   (q_full)
	);

	fstc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_req),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	fstc_back #(
		.NUM_FANS (NUM_FANS),
		.STEPS    (STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (q_head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== hw/rtl/fstc_checker.sv =====
// Port-level checks on the result stream of the fan speed trend controller,
// bound to the top level. Depends on fstc_pkg.
`timescale 1ns / 1ps

module fstc_checker #(
	parameter int NUM_FANS = 4,
	parameter int STEPS    = 20
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [fstc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tlast
);
	import fstc_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// step never exceeds the top step
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_STEP_LSB +: STEP_W] <= STEP_W'(STEPS))
		else $error("speed step above STEPS");

	// within a run the next fan follows at once
	a_next_fan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid &&
			(m_tdata[OUT_IDX_LSB +: FIDX_W] == $past(m_tdata[OUT_IDX_LSB +: FIDX_W]) + 2'd1))
		else $error("fan run broken");

	// a new run starts at fan zero
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid || (m_tdata[OUT_IDX_LSB +: FIDX_W] == '0))
		else $error("run does not start at fan zero");

endmodule

bind fan_speed_trend_controller fstc_checker #(
	.NUM_FANS (NUM_FANS),
	.STEPS    (STEPS)
) u_fstc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== tb/fan_speed_trend_controller_tb.sv =====
// Self-checking bench for the fan speed trend controller: drives sample streams
// under several threshold and speed settings and checks every fan speed result.
// Depends on fstc_pkg and the fan_speed_trend_controller top level.
`timescale 1ns / 1ps

module fan_speed_trend_controller_tb;
	import fstc_pkg::*;

	localparam int NUM_FANS       = 4;
	localparam int STEPS          = 20;
	localparam int RANDOM_PER_SET = 35;
	localparam int IDLE_SETTLE    = 300;   // covers queued remaps that emit nothing
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_AT       = 150;

	typedef struct packed {
		logic [FIDX_W-1:0] idx;
		logic [RPM_W-1:0]  rpm;
		logic [STEP_W-1:0] step;
		logic              last;
	} fan_speed_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	fan_speed_trend_controller #(
		.NUM_FANS(NUM_FANS),
		.STEPS(STEPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow configuration and trend state
	logic [TEMP_W-1:0] lim_low = TEMP_LOW_RST;
	logic [TEMP_W-1:0] lim_high = TEMP_HIGH_RST;
	logic [RPM_W-1:0]  rpm_min = FAN_MIN_RPM_RST;
	logic [RPM_W-1:0]  rpm_max = FAN_MAX_RPM_RST;
	logic              seen_first = 1'b0;
	logic [TEMP_W-1:0] last_deg = '0;
	logic [CNT_W-1:0]  rise_run = '0;
	logic [CNT_W-1:0]  fall_run = '0;
	logic [STEP_W-1:0] active_step = '0;

	logic [TEMP_IN_W-1:0] sample_queue[$];
	fan_speed_t           expected_speeds[$];
	int                   samples_taken = 0;
	int                   mismatches = 0;
	logic                 s_fire = 1'b0;

	// Walk state for the random samples
	int walk_deg = 75;
	int run_dir = 1;
	int run_left = 0;

	// Opening run: first sample, field extremes, saturation, equal samples,
	// remaps with and without a step change, broken trends
	logic [TEMP_IN_W-1:0] opening_run [23] = '{
		18'd75500, 18'd76000, 18'd76999, 18'd90000, 18'd255999, 18'd262143,
		18'd256000, 18'd0, 18'd0, 18'd69999, 18'd70000, 18'd65000, 18'd60000,
		18'd80000, 18'd80500, 18'd85000, 18'd79000, 18'd71000, 18'd71999,
		18'd72000, 18'd71000, 18'd70500, 18'd174762
	};

	function automatic logic [STEP_W-1:0] step_for_temp(logic [TEMP_W-1:0] t);
		int q;
		if (lim_high <= lim_low)
			return (t >= lim_high) ? STEP_W'(STEPS) : '0;
		if (t <= lim_low)
			return '0;
		q = ((int'(t) - int'(lim_low)) * STEPS) / (int'(lim_high) - int'(lim_low));
		return (q > STEPS) ? STEP_W'(STEPS) : STEP_W'(q);
	endfunction

	// One result per fan; the quotient truncates toward zero
	task automatic queue_fan_speeds(logic [STEP_W-1:0] step);
		int         span;
		int         q;
		fan_speed_t fs;
		span = int'(rpm_max) - int'(rpm_min);
		q = (int'(step) * span) / STEPS;
		for (int i = 0; i < NUM_FANS; i++) begin
			fs.idx  = FIDX_W'(i);
			fs.rpm  = RPM_W'(int'(rpm_min) + q);
			fs.step = step;
			fs.last = (i == NUM_FANS - 1);
			expected_speeds.push_back(fs);
		end
	endtask

	task automatic predict_sample(logic [TEMP_IN_W-1:0] milli);
		int                deg;
		logic [TEMP_W-1:0] t;
		logic [STEP_W-1:0] s;
		deg = int'(milli) / 1000;
		t = (deg > 255) ? 8'd255 : TEMP_W'(deg);
		if (!seen_first) begin
			seen_first = 1'b1;
			last_deg = t;
			rise_run = 2'd1;
			fall_run = 2'd1;
			active_step = step_for_temp(t);
			queue_fan_speeds(active_step);
			return;
		end
		if (t < last_deg) begin
			fall_run = fall_run + 2'd1;
			rise_run = '0;
		end
		if (t > last_deg) begin
			rise_run = rise_run + 2'd1;
			fall_run = '0;
		end
		if (fall_run == TREND_HIT || rise_run == TREND_HIT) begin
			s = step_for_temp(t);
			if (s != active_step) begin
				queue_fan_speeds(s);
				active_step = s;
			end
			fall_run = '0;
			rise_run = '0;
		end
		last_deg = t;
	endtask

	// Mostly trend runs around the threshold window, some equal samples and noise
	function automatic logic [TEMP_IN_W-1:0] next_random_sample();
		int lo_w;
		int hi_w;
		int r;
		lo_w = ((lim_low < lim_high) ? int'(lim_low) : int'(lim_high)) - 8;
		hi_w = ((lim_low < lim_high) ? int'(lim_high) : int'(lim_low)) + 8;
		r = $urandom_range(0, 99);
		if (r < 12)
			return TEMP_IN_W'($urandom);
		if (run_left == 0) begin
			run_left = $urandom_range(1, 5);
			if (walk_deg < lo_w)
				run_dir = 1;
			else if (walk_deg > hi_w)
				run_dir = -1;
			else
				run_dir = ($urandom_range(0, 1) != 0) ? 1 : -1;
		end
		run_left--;
		if (r < 85)
			walk_deg += run_dir * int'($urandom_range(1, 6));
		if (walk_deg < 0)
			walk_deg = 0;
		if (walk_deg > 255)
			walk_deg = 255;
		if (walk_deg == 255 && $urandom_range(0, 1) != 0)
			return TEMP_IN_W'($urandom_range(255000, 262143));
		return TEMP_IN_W'(walk_deg * 1000 + int'($urandom_range(0, 999)));
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_TEMP_LOW:    lim_low = value[TEMP_W-1:0];
			REG_TEMP_HIGH:   lim_high = value[TEMP_W-1:0];
			REG_FAN_MIN_RPM: rpm_min = value;
			REG_FAN_MAX_RPM: rpm_max = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_until_idle();
		do
			@(negedge clk);
		while (sample_queue.size() != 0 || s_tvalid || expected_speeds.size() != 0);
		repeat (IDLE_SETTLE) @(negedge clk);
	endtask

	// Temperature registers get junk in the unused upper data bits
	task automatic run_setting(int lo, int hi, int mn, int mx, int count);
		write_reg(REG_TEMP_LOW, {5'($urandom), 8'(lo)});
		write_reg(REG_TEMP_HIGH, {5'($urandom), 8'(hi)});
		write_reg(REG_FAN_MIN_RPM, 13'(mn));
		write_reg(REG_FAN_MAX_RPM, 13'(mx));
		for (int i = 0; i < count; i++)
			sample_queue.push_back(next_random_sample());
		wait_until_idle();
	endtask

	// Sequencer: reset, opening run, then a series of settings
	initial begin
		int lo;
		int hi;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (opening_run[i])
			sample_queue.push_back(opening_run[i]);
		for (int i = 0; i < RANDOM_PER_SET; i++)
			sample_queue.push_back(next_random_sample());
		wait_until_idle();

		run_setting(0, 255, 0, 8191, RANDOM_PER_SET);
		run_setting(100, 100, 8191, 0, RANDOM_PER_SET);
		run_setting(255, 0, 5000, 5000, RANDOM_PER_SET);
		run_setting(200, 50, 4321, 123, RANDOM_PER_SET);
		run_setting(254, 255, 0, 0, RANDOM_PER_SET);
		for (int k = 0; k < 4; k++) begin
			lo = $urandom_range(0, 255);
			if ($urandom_range(0, 3) != 0)
				hi = (lo + int'($urandom_range(1, 40)) > 255) ? 255 :
				     lo + int'($urandom_range(1, 40));
			else
				hi = $urandom_range(0, 255);
			run_setting(lo, hi, $urandom_range(0, 8191), $urandom_range(0, 8191),
			            RANDOM_PER_SET);
		end
		run_setting(TEMP_LOW_RST, TEMP_HIGH_RST, FAN_MIN_RPM_RST, FAN_MAX_RPM_RST,
		            RANDOM_PER_SET);

		if (mismatches == 0 && expected_speeds.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Sample driver: bursts and gaps, one pause until all results are back
	int burst_left = 8;
	int gap_left = 0;
	bit draining = 1'b0;
	bit drain_done = 1'b0;

	always @(negedge clk) begin
		if (!drain_done && !draining && samples_taken >= DRAIN_AT)
			draining = 1'b1;
		if (!(s_tvalid && !s_fire)) begin
			if (draining) begin
				s_tvalid <= 1'b0;
				if (expected_speeds.size() == 0) begin
					draining = 1'b0;
					drain_done = 1'b1;
				end
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				s_tdata <= IN_TDATA_W'(sample_queue.pop_front());
				s_tvalid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 16);
					case ($urandom_range(0, 9))
						0, 1, 2, 3: gap_left = 0;
						8:          gap_left = $urandom_range(10, 60);
						9: begin
							gap_left = 0;
							burst_left = $urandom_range(30, 60);
						end
						default:    gap_left = $urandom_range(1, 6);
					endcase
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: ready density changes by stretch, two long hold-offs
	int hold_left = 0;
	int holds_done = 0;
	int mode_left = 0;
	int ready_pct = 100;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (s_tvalid && ((holds_done == 0 && samples_taken >= 60) ||
		                          (holds_done == 1 && samples_taken >= 320))) begin
			hold_left = HOLD_CYCLES;
			holds_done++;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 200);
				case ($urandom_range(0, 3))
					0:       ready_pct = 100;
					1:       ready_pct = 80;
					2:       ready_pct = 45;
					default: ready_pct = 15;
				endcase
			end
			mode_left--;
			m_tready <= ($urandom_range(1, 100) <= ready_pct);
		end
	end

	// Monitor: predict on each sample request, check each result request
	always @(posedge clk) begin
		fan_speed_t want;
		s_fire <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			predict_sample(s_tdata[TEMP_IN_W-1:0]);
			samples_taken++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_speeds.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result idx %0d rpm %0d step %0d last %0d",
				         $time, m_tdata[OUT_SPD_LSB-1:OUT_IDX_LSB],
				         m_tdata[OUT_STEP_LSB-1:OUT_SPD_LSB],
				         m_tdata[OUT_USED_W-1:OUT_STEP_LSB], m_tlast);
			end else begin
				want = expected_speeds.pop_front();
				if (m_tdata[OUT_SPD_LSB-1:OUT_IDX_LSB] !== want.idx ||
				    m_tdata[OUT_STEP_LSB-1:OUT_SPD_LSB] !== want.rpm ||
				    m_tdata[OUT_USED_W-1:OUT_STEP_LSB] !== want.step ||
				    m_tlast !== want.last) begin
					mismatches++;
					$display("%0t: mismatch expected idx %0d rpm %0d step %0d last %0d",
					         $time, want.idx, want.rpm, want.step, want.last);
					$display("%0t:          actual   idx %0d rpm %0d step %0d last %0d",
					         $time, m_tdata[OUT_SPD_LSB-1:OUT_IDX_LSB],
					         m_tdata[OUT_STEP_LSB-1:OUT_SPD_LSB],
					         m_tdata[OUT_USED_W-1:OUT_STEP_LSB], m_tlast);
				end
			end
		end
	end

	// Watchdog on cycles with no request on either side
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
			         expected_speeds.size());
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
hw/rtl/fstc_pkg.sv
hw/rtl/fstc_div.sv
hw/rtl/fstc_queue.sv
hw/rtl/fstc_front.sv
hw/rtl/fstc_back.sv
hw/rtl/fan_speed_trend_controller.sv
hw/rtl/fstc_checker.sv
tb/fan_speed_trend_controller_tb.sv
